// ===== rtl/matrix_max_falling_path_sum_assert.svh =====
// Assertion macros shared by the RTL of the falling path sum block.
// Each macro expects i_clk and i_rst_n in scope and is disabled in reset.
`ifndef MATRIX_MAX_FALLING_PATH_SUM_ASSERT_SVH
`define MATRIX_MAX_FALLING_PATH_SUM_ASSERT_SVH

// Same-cycle implication
`define MMFPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication
`define MMFPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/mmfps_pkg.sv =====
package mmfps_pkg;

    // field widths
    localparam int VAL_W = 16;
    localparam int SUM_W = 32;
    localparam int CFG_W = 7;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [SUM_W-1:0] t_sum;

    // saturation limits of a path sum
    localparam t_sum SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // broadcast control to the row-buffer cells
    typedef struct packed {
        logic adv;   // transaction taken, column moves right
        logic wrap;  // transaction taken, row ends, column returns to 0
    } t_cell_ctl;

endpackage

// ===== rtl/mmfps_cell.sv =====
// One column of the row buffer: holds the best path sum of its column and
// the column token, which moves to the right-hand neighbor per transaction.
module mmfps_cell import mmfps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_home,       // this cell is column 0
    input  t_cell_ctl i_ctl,
    input  logic      i_tok_prev,   // left neighbor's current token
    input  logic      i_ntok_prev,  // left neighbor's next token
    input  t_sum      i_wr_data,
    output logic      o_tok,
    output logic      o_ntok,
    output t_sum      o_rd_up,      // own sum if next column is this one
    output t_sum      o_rd_upr      // own sum if next column is left neighbor
);

    logic r_tok;
    logic n_tok;
    t_sum r_val;

    // token movement
    always_comb begin
        n_tok = r_tok;
        if (i_ctl.wrap) begin
            n_tok = i_home;
        end else if (i_ctl.adv) begin
            n_tok = i_tok_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= i_home;
        end else begin
            r_tok <= n_tok;
        end
    end

    // column sum, written when the token sits here
    always_ff @(posedge i_clk) begin
        if ((i_ctl.adv | i_ctl.wrap) && r_tok) begin
            r_val <= i_wr_data;
        end
    end

    assign o_tok    = r_tok;
    assign o_ntok   = n_tok;
    assign o_rd_up  = n_tok ? r_val : '0;
    assign o_rd_upr = i_ntok_prev ? r_val : '0;

endmodule

// ===== rtl/matrix_max_falling_path_sum.sv =====
// Maximum falling path sum over a streamed matrix.
// s_axis carries one cell per transaction in row-major order: tdata is the
// signed 16-bit cell value, tuser is set on every cell of the last row.
// i_cfg_* writes the column count (1..MAX_COLS; 0 acts as 1, larger values
// as MAX_COLS); o_cfg_ready is always high. Write it only while idle.
// m_axis carries one transaction per matrix: tdata is the best 32-bit path
// sum ending in the last row, tuser flags that some sum was saturated.
// Throughput: one cell per clock while s_axis_tready is high, set by the
// single add/compare step that reads the previous row from the column cells,
// one cell per column. On the last cell of the last row the second stage
// registers its path sum, then the result buffer stores the final running
// maximum and raises m_axis_tvalid if it was low.
// Up to two results are buffered; when the receiver stalls, s_axis_tready
// drops once a further result could not be stored.
// Reset (synchronous, active low) returns to the first row of a new matrix,
// clears running maximum and saturation flag and sets the column count to
// MAX_COLS, at most 64; the row buffer contents are kept and need no clearing pass.
`include "matrix_max_falling_path_sum_assert.svh"

module matrix_max_falling_path_sum import mmfps_pkg::*; #(
    parameter int MAX_COLS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,     // num_cols
    // cell stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [15:0] cell_value
    input  logic             s_axis_tuser,   // [0] final_row
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] max_sum
    output logic             m_axis_tuser    // [0] saturated
);

    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RST_LAST = (MAX_COLS < 64) ? MAX_COLS - 1 : 63;

    logic [COL_W-1:0] r_last;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_first;
    t_sum             r_left;
    t_sum             r_up;
    t_sum             r_upr;
    t_sum             n_up;
    t_sum             n_upr;
    logic             r_ovf;

    logic             w_accept;
    logic             w_row_end;
    logic             w_has_left;
    logic             w_has_right;
    logic             w_fin;
    t_val             w_val;
    t_sum             w_best;
    logic signed [SUM_W:0] w_sum_wide;
    logic             w_pos_ovf;
    logic             w_neg_ovf;
    logic             w_sat;
    t_sum             w_sum;

    t_cell_ctl        w_ctl;
    logic [MAX_COLS-1:0] w_tok;
    logic [MAX_COLS-1:0] w_ntok;
    t_sum             w_up [MAX_COLS];
    t_sum             w_upr [MAX_COLS];
    t_sum             w_up_or;
    t_sum             w_upr_or;

    logic             r_b_valid;
    t_sum             r_b_sum;
    logic             r_b_fin;
    logic             r_b_end;
    logic             r_b_ovf;
    t_sum             r_max;
    t_sum             w_max_now;
    logic             w_push;

    logic             r_o_valid;
    t_sum             r_o_sum;
    logic             r_o_sat;
    logic             r_sk_valid;
    t_sum             r_sk_sum;
    logic             r_sk_sat;
    logic             w_pop;
    logic [1:0]       w_occ;

    // configuration: store last column index, clamped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= COL_W'(RST_LAST);
        end else if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                r_last <= '0;
            end else if (32'(i_cfg_data) > MAX_COLS) begin
                r_last <= COL_W'(MAX_COLS - 1);
            end else begin
                r_last <= COL_W'(i_cfg_data - CFG_W'(1));
            end
        end
    end

    // row position decode
    assign w_accept    = s_axis_tvalid & s_axis_tready;
    assign w_val       = s_axis_tdata;
    assign w_fin       = s_axis_tuser;
    assign w_row_end   = (r_col >= r_last);
    assign w_has_right = (r_col < r_last);
    assign w_has_left  = (r_col != '0);

    // best of up, up-left and up-right
    always_comb begin
        w_best = r_up;
        if (w_has_left && (r_left > w_best)) begin
            w_best = r_left;
        end
        if (w_has_right && (r_upr > w_best)) begin
            w_best = r_upr;
        end
    end

    // saturating add
    assign w_sum_wide = (SUM_W+1)'(w_val) + (SUM_W+1)'(w_best);
    assign w_pos_ovf  = !w_sum_wide[SUM_W] && w_sum_wide[SUM_W-1];
    assign w_neg_ovf  = w_sum_wide[SUM_W] && !w_sum_wide[SUM_W-1];
    assign w_sat      = !r_first && (w_pos_ovf || w_neg_ovf);

    always_comb begin
        if (r_first) begin
            w_sum = t_sum'(w_val);
        end else if (w_pos_ovf) begin
            w_sum = SUM_MAX;
        end else if (w_neg_ovf) begin
            w_sum = SUM_MIN;
        end else begin
            w_sum = w_sum_wide[SUM_W-1:0];
        end
    end

    // column cells
    assign w_ctl.adv  = w_accept && !w_row_end;
    assign w_ctl.wrap = w_accept && w_row_end;

    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        logic w_tok_prev;
        logic w_ntok_prev;
        if (k == 0) begin : g_head
            assign w_tok_prev  = 1'b0;
            assign w_ntok_prev = 1'b0;
        end else begin : g_body
            assign w_tok_prev  = w_tok[k-1];
            assign w_ntok_prev = w_ntok[k-1];
        end
        mmfps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_home      (1'(k == 0)),
            .i_ctl       (w_ctl),
            .i_tok_prev  (w_tok_prev),
            .i_ntok_prev (w_ntok_prev),
            .i_wr_data   (w_sum),
            .o_tok       (w_tok[k]),
            .o_ntok      (w_ntok[k]),
            .o_rd_up     (w_up[k]),
            .o_rd_upr    (w_upr[k])
        );
    end

    // gather the cells' read data for the next cell
    always_comb begin
        w_up_or  = '0;
        w_upr_or = '0;
        for (int k = 0; k < MAX_COLS; k++) begin
            w_up_or  = w_up_or | w_up[k];
            w_upr_or = w_upr_or | w_upr[k];
        end
    end

    // next column and prefetch with bypass of the sum being written
    always_comb begin
        n_col = r_col;
        if (w_accept) begin
            n_col = w_row_end ? '0 : r_col + 1'b1;
        end
        n_up = w_up_or;
        if (w_accept && (n_col == r_col)) begin
            n_up = w_sum;
        end
        n_upr = w_upr_or;
        if (w_accept && (((COL_W+1)'(n_col) + (COL_W+1)'(1)) == (COL_W+1)'(r_col))) begin
            n_upr = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up  <= n_up;
        r_upr <= n_upr;
    end

    // row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
            r_left  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_col <= n_col;
            if (w_accept) begin
                r_left <= w_row_end ? '0 : r_up;
                r_ovf  <= (w_row_end && w_fin) ? 1'b0 : (r_ovf | w_sat);
                if (w_row_end) begin
                    r_first <= w_fin;
                end
            end
        end
    end

    // second stage: running maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_sum <= w_sum;
            r_b_fin <= w_fin;
            r_b_end <= w_row_end && w_fin;
            r_b_ovf <= r_ovf | w_sat;
        end
    end

    assign w_max_now = (r_b_valid && r_b_fin && (r_b_sum > r_max)) ? r_b_sum : r_max;
    assign w_push    = r_b_valid && r_b_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= SUM_MIN;
        end else if (w_push) begin
            r_max <= SUM_MIN;
        end else begin
            r_max <= w_max_now;
        end
    end

    // two-entry result buffer
    assign w_pop         = r_o_valid && m_axis_tready;
    assign w_occ         = 2'(r_o_valid) + 2'(r_sk_valid) + 2'(w_push) - 2'(w_pop);
    assign s_axis_tready = (w_occ <= 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_o_valid || w_pop) begin
            if (r_sk_valid) begin
                r_o_valid  <= 1'b1;
                r_sk_valid <= w_push;
            end else begin
                r_o_valid  <= w_push;
                r_sk_valid <= 1'b0;
            end
        end else if (w_push) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || w_pop) begin
            if (r_sk_valid) begin
                r_o_sum <= r_sk_sum;
                r_o_sat <= r_sk_sat;
                if (w_push) begin
                    r_sk_sum <= w_max_now;
                    r_sk_sat <= r_b_ovf;
                end
            end else if (w_push) begin
                r_o_sum <= w_max_now;
                r_o_sat <= r_b_ovf;
            end
        end else if (w_push) begin
            r_sk_sum <= w_max_now;
            r_sk_sat <= r_b_ovf;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_sum;
    assign m_axis_tuser  = r_o_sat;

    // checks
    `MMFPS_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot(w_tok))
    `MMFPS_ASSERT_NOW(a_tok_at_col, 1'b1, w_tok[r_col])
    `MMFPS_ASSERT_NEXT(a_row_wrap, w_accept && w_row_end, (r_col == '0) && w_tok[0])
    `MMFPS_ASSERT_NOW(a_skid_order, r_sk_valid, r_o_valid)
    `MMFPS_ASSERT_NOW(a_no_overrun, r_o_valid && r_sk_valid && !w_pop, !w_push)

endmodule
